// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker of the project (slcfp_checker.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/slcfp_pkg.sv =====
// Package for the sync/length/checksum frame parser: constants, types, command decode
`timescale 1ns / 1ps

package slcfp_pkg;

    localparam int unsigned MAX_FRAME_LEN_DEF = 64;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [3:0] CMD_GROUP   = 4'hB;
    localparam logic [3:0] CMD_RED     = 4'h1;
    localparam logic [3:0] CMD_GREEN   = 4'h2;
    localparam logic [3:0] CMD_BLUE    = 4'h3;

    // Result of one byte: flags plus LED levels after the update
    typedef struct packed {
        logic       frame_ok;
        logic       checksum_error;
        logic       length_error;
        logic [2:0] led;            // bit0 red, bit1 green, bit2 blue
    } result_t;

    // Apply an LED command to the current channel bits
    function automatic logic [2:0] apply_cmd(input logic [7:0] first_b,
                                             input logic [7:0] second_b,
                                             input logic [2:0] led);
        logic [2:0] sel;
        sel = 3'b000;
        if (first_b[7:4] == CMD_GROUP) begin
            case (first_b[3:0])
                CMD_RED:   sel = 3'b001;
                CMD_GREEN: sel = 3'b010;
                CMD_BLUE:  sel = 3'b100;
                default:   sel = 3'b000;
            endcase
        end
        if (second_b != 8'h00) begin
            return led | sel;
        end
        return led & ~sel;
    endfunction

endpackage

// ===== design/slcfp_core.sv =====
// Frame parser state and per-byte next-state logic
`timescale 1ns / 1ps

module slcfp_core #(
    parameter int unsigned MAX_FRAME_LEN = slcfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output slcfp_pkg::result_t  result
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_SYNC1  = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;
    localparam logic [7:0] MAX_LEN   = 8'(MAX_FRAME_LEN);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [2:0] led_reg, led_next;
    logic       in_payload;

    // Payload while count + 1 < length (length zero never counts as payload)
    assign in_payload = ({1'b0, count_reg} + 9'd1) < {1'b0, len_reg};

    // Next state for one byte
    always_comb begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        first_next  = first_reg;
        second_next = second_reg;
        led_next    = led_reg;
        result      = '0;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == slcfp_pkg::SYNC_FIRST) begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_SYNC1: begin
                phase_next = (rx_byte == slcfp_pkg::SYNC_SECOND) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH: begin
                if (rx_byte == 8'h00) begin
                    phase_next = PH_HUNT;
                end else begin
                    len_next   = rx_byte;
                    count_next = 8'h00;
                    if (rx_byte > MAX_LEN) begin
                        phase_next          = PH_HUNT;
                        sum_next            = 8'h00;
                        result.length_error = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                        sum_next   = rx_byte;
                    end
                end
            end
            PH_BODY: begin
                if (in_payload) begin
                    if (count_reg == 8'd0) begin
                        first_next = rx_byte;
                    end else if (count_reg == 8'd1) begin
                        second_next = rx_byte;
                    end
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_reg + 8'd1;
                end else begin
                    // checksum byte closes the frame
                    if (rx_byte == sum_reg) begin
                        result.frame_ok = 1'b1;
                        led_next = slcfp_pkg::apply_cmd(first_reg, second_reg, led_reg);
                    end else begin
                        result.checksum_error = 1'b1;
                    end
                    sum_next   = 8'h00;
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
        result.led = led_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            len_reg    <= 8'h00;
            count_reg  <= 8'h00;
            sum_reg    <= 8'h00;
            first_reg  <= 8'h00;
            second_reg <= 8'h00;
            led_reg    <= 3'b000;
        end else if (step) begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            led_reg    <= led_next;
        end
    end

endmodule

// ===== design/sync_length_checksum_frame_parser_top.sv =====
// Top level: input register, parser core, result register
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_rx_byte[7:0]
//  m_      | out       | m_valid / m_ready | flags, red/green/blue levels
//
// One byte per cycle sustained while results are taken; a byte's result
// reaches the m_ side through the input register, then the result register
// behind the parser logic.
// Synchronous active-low reset clears the parser state and both valid flags.
// A stalled result holds the parser; an empty input register still takes one
// more byte, then s_ready drops until the result is taken.
`timescale 1ns / 1ps

module sync_length_checksum_frame_parser_top #(
    parameter int unsigned MAX_FRAME_LEN = slcfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_frame_ok,
    output logic       m_checksum_error,
    output logic       m_length_error,
    output logic       m_red_on,
    output logic       m_green_on,
    output logic       m_blue_on
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    slcfp_pkg::result_t out_reg;
    slcfp_pkg::result_t core_result;
    logic               fire;

    // Process the held byte when the result register is free or being taken
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    slcfp_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_ok       = out_reg.frame_ok;
    assign m_checksum_error = out_reg.checksum_error;
    assign m_length_error   = out_reg.length_error;
    assign m_red_on         = out_reg.led[0];
    assign m_green_on       = out_reg.led[1];
    assign m_blue_on        = out_reg.led[2];

endmodule

// ===== design/slcfp_checker.sv =====
// Port-level checker for the frame parser, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slcfp_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_frame_ok,
    input logic m_checksum_error,
    input logic m_length_error,
    input logic m_red_on,
    input logic m_green_on,
    input logic m_blue_on
);

    logic       m_stall;
    logic       m_xfer;
    logic       m_xfer_plain;
    logic [2:0] m_flags;
    logic [2:0] m_leds;
    logic [5:0] m_payload;

    // Handshake and payload views of the result channel
    assign m_stall      = m_valid && !m_ready;
    assign m_xfer       = m_valid && m_ready;
    assign m_xfer_plain = m_xfer && !m_frame_ok;
    assign m_flags      = {m_frame_ok, m_checksum_error, m_length_error};
    assign m_leds       = {m_blue_on, m_green_on, m_red_on};
    assign m_payload    = {m_flags, m_leds};

    // Stalled result holds its payload
    `ASSERT_RUN(a_out_hold, aclk, aresetn, m_stall |=> m_valid && $stable(m_payload), "stall moved data")

    // At most one outcome flag per transfer
    `ASSERT_RUN(a_flags_excl, aclk, aresetn, m_valid |-> $onehot0(m_flags), "two outcome flags")

    // No result straight after reset
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // LED levels change only on a good frame
    `ASSERT_RUN(a_led_hold, aclk, aresetn, m_xfer ##1 m_xfer_plain |-> $stable(m_leds), "LED moved")

endmodule

bind sync_length_checksum_frame_parser_top slcfp_checker u_slcfp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_frame_ok       (m_frame_ok),
    .m_checksum_error (m_checksum_error),
    .m_length_error   (m_length_error),
    .m_red_on         (m_red_on),
    .m_green_on       (m_green_on),
    .m_blue_on        (m_blue_on)
);

// ===== tb/sv/frame_checker.sv =====
// Checker for the frame parser: predicts each byte's result and compares it on the m_ side
`timescale 1ns / 1ps

module frame_checker #(
    parameter int unsigned MAX_LEN = slcfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_frame_ok,
    input  logic       m_checksum_error,
    input  logic       m_length_error,
    input  logic       m_red_on,
    input  logic       m_green_on,
    input  logic       m_blue_on,
    output int         fail_count,
    output int         outstanding
);

    localparam logic [1:0] PH_HUNT_FIRST  = 2'd0;
    localparam logic [1:0] PH_HUNT_SECOND = 2'd1;
    localparam logic [1:0] PH_LENGTH      = 2'd2;
    localparam logic [1:0] PH_BODY        = 2'd3;

    // Shadow copy of the parser state
    logic [1:0]   ph;
    logic [7:0]   frame_len;
    logic [7:0]   body_count;
    logic [7:0]   sum_acc;
    logic [7:0]   first_b;
    logic [7:0]   second_b;
    logic [2:0]   leds;

    slcfp_pkg::result_t pending_results[$];
    int                 result_no;

    // Advance the shadow parser by one byte and give the result it should produce
    function automatic slcfp_pkg::result_t parse_byte(input logic [7:0] b);
        slcfp_pkg::result_t r;
        logic [2:0]         mask;
        r = '0;
        mask = 3'b000;
        case (ph)
            PH_HUNT_FIRST: begin
                if (b == slcfp_pkg::SYNC_FIRST) ph = PH_HUNT_SECOND;
            end
            PH_HUNT_SECOND: begin
                // a failed second sync goes straight back to the hunt
                ph = (b == slcfp_pkg::SYNC_SECOND) ? PH_LENGTH : PH_HUNT_FIRST;
            end
            PH_LENGTH: begin
                if (b == 8'h00) begin
                    ph = PH_HUNT_FIRST;
                end else begin
                    ph = PH_BODY;
                    sum_acc = b;
                    frame_len = b;
                    body_count = 8'h00;
                    if (b > MAX_LEN) begin
                        ph = PH_HUNT_FIRST;
                        sum_acc = 8'h00;
                        r.length_error = 1'b1;
                    end
                end
            end
            default: begin
                if (int'(body_count) < int'(frame_len) - 1) begin
                    if (body_count == 8'd0) first_b = b;
                    else if (body_count == 8'd1) second_b = b;
                    sum_acc = sum_acc + b;
                    body_count = body_count + 8'd1;
                end else begin
                    if (b == sum_acc) begin
                        r.frame_ok = 1'b1;
                        // LED command, decoded from the kept payload bytes
                        if (first_b[7:4] == slcfp_pkg::CMD_GROUP) begin
                            case (first_b[3:0])
                                slcfp_pkg::CMD_RED:   mask = 3'b001;
                                slcfp_pkg::CMD_GREEN: mask = 3'b010;
                                slcfp_pkg::CMD_BLUE:  mask = 3'b100;
                                default:              mask = 3'b000;
                            endcase
                        end
                        if (second_b != 8'h00) leds = leds | mask;
                        else leds = leds & ~mask;
                    end else begin
                        r.checksum_error = 1'b1;
                    end
                    sum_acc = 8'h00;
                    ph = PH_HUNT_FIRST;
                end
            end
        endcase
        r.led = leds;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: result %0d, %s expected %0b, actual %0b",
                     $time, result_no, name, want, got);
        end
    endfunction

    // Watch both channels: results are checked before the new byte is predicted
    always @(posedge aclk) begin : monitor
        slcfp_pkg::result_t want;
        if (!aresetn) begin
            ph = PH_HUNT_FIRST;
            frame_len = 8'h00;
            body_count = 8'h00;
            sum_acc = 8'h00;
            first_b = 8'h00;
            second_b = 8'h00;
            leds = 3'b000;
            pending_results.delete();
            result_no = 0;
            outstanding = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result %0d arrived with no byte waiting for it",
                             $time, result_no);
                end else begin
                    want = pending_results.pop_front();
                    check_field("frame_ok", want.frame_ok, m_frame_ok);
                    check_field("checksum_error", want.checksum_error, m_checksum_error);
                    check_field("length_error", want.length_error, m_length_error);
                    check_field("red_on", want.led[0], m_red_on);
                    check_field("green_on", want.led[1], m_green_on);
                    check_field("blue_on", want.led[2], m_blue_on);
                end
                result_no++;
            end
            if (s_valid && s_ready) pending_results.push_back(parse_byte(s_rx_byte));
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the frame parser: clock, reset, byte stimulus, result stalls and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET = 650;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_LEN     = slcfp_pkg::MAX_FRAME_LEN_DEF;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_frame_ok;
    logic       m_checksum_error;
    logic       m_length_error;
    logic       m_red_on;
    logic       m_green_on;
    logic       m_blue_on;

    int fail_count;
    int outstanding;
    bit gaps_on;
    int bytes_sent;
    int stall_left;
    int quiet_cycles;
    int pick;

    sync_length_checksum_frame_parser_top #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_ok      (m_frame_ok),
        .m_checksum_error(m_checksum_error),
        .m_length_error  (m_length_error),
        .m_red_on        (m_red_on),
        .m_green_on      (m_green_on),
        .m_blue_on       (m_blue_on)
    );

    frame_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_ok      (m_frame_ok),
        .m_checksum_error(m_checksum_error),
        .m_length_error  (m_length_error),
        .m_red_on        (m_red_on),
        .m_green_on      (m_green_on),
        .m_blue_on       (m_blue_on),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random stall bursts while gaps are enabled
    initial begin
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // One byte on the s_ side; entered and left at a falling edge, valid left high
    task automatic push_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Header, length, payload and checksum; the payload leans towards LED commands
    task automatic push_frame(input logic [7:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_SECOND);
        push_byte(len);
        if (len == 8'h00 || len > MAX_LEN) return;
        sum = len;
        for (i = 0; i < int'(len) - 1; i++) begin
            if (i == 0)
                b = ($urandom_range(0, 3) != 0)
                    ? {slcfp_pkg::CMD_GROUP, 4'($urandom_range(0, 4))}
                    : 8'($urandom);
            else if (i == 1)
                b = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
            else
                b = 8'($urandom);
            sum = sum + b;
            push_byte(b);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    // Hold the sender off until every result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        aresetn = 1'b0;
        gaps_on = 1'b1;
        bytes_sent = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero length, oversize lengths, bad second sync,
        // one-byte frame on stale bytes, LED on, wrong checksum
        push_frame(8'h00, 1'b0);
        push_frame(8'(MAX_LEN + 1), 1'b0);
        push_frame(8'hFF, 1'b0);
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_SECOND);
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_SECOND);
        push_byte(8'h01);
        push_byte(8'h01);
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_SECOND);
        push_byte(8'h03);
        push_byte({slcfp_pkg::CMD_GROUP, slcfp_pkg::CMD_RED});
        push_byte(8'h01);
        push_byte(8'h03 + {slcfp_pkg::CMD_GROUP, slcfp_pkg::CMD_RED} + 8'h01);
        push_byte(slcfp_pkg::SYNC_FIRST);
        push_byte(slcfp_pkg::SYNC_SECOND);
        push_byte(8'h02);
        push_byte({slcfp_pkg::CMD_GROUP, slcfp_pkg::CMD_GREEN});
        push_byte(8'h00);
        wait_drained();

        // Longest legal frame, then random traffic
        push_frame(8'(MAX_LEN), 1'b0);
        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent > ITEM_TARGET - 100) gaps_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_frame(8'($urandom_range(1, 6)), $urandom_range(0, 7) == 0);
            end else if (pick < 78) begin
                push_frame(8'($urandom_range(7, 20)), $urandom_range(0, 7) == 0);
            end else if (pick < 80) begin
                push_frame(8'($urandom_range(MAX_LEN - 1, MAX_LEN)), $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                push_frame(($urandom_range(0, 1) != 0) ? 8'h00
                                                       : 8'($urandom_range(MAX_LEN + 1, 255)),
                           1'b0);
            end else if (pick < 90) begin
                // broken header
                push_byte(slcfp_pkg::SYNC_FIRST);
                push_byte(($urandom_range(0, 1) != 0) ? slcfp_pkg::SYNC_FIRST : 8'($urandom));
            end else if (pick < 92) begin
                wait_drained();
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            end
        end

        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (outstanding != 0)
            $display("%0t: %0d results never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
